// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the JSON string unescaper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu: next-cycle check failed");

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and decode helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       closed_by_quote;
    } t_out_req;

    typedef enum logic [3:0] {
        MODE_TEXT   = 4'd0,
        MODE_ESC    = 4'd1,
        MODE_HEX1   = 4'd2,
        MODE_WAITBS = 4'd3,
        MODE_WAITU  = 4'd4,
        MODE_HEX2   = 4'd5
    } t_mode;

    // Up to four results caused by one input request.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            term;
        logic            quote;
    } t_grp;

    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_V      = 8'h76;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;

    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;

    localparam logic [20:0] UTF8_LIM1   = 21'h00080;
    localparam logic [20:0] UTF8_LIM2   = 21'h00800;
    localparam logic [20:0] UTF8_LIM3   = 21'h10000;
    localparam logic [20:0] SUPPL_BASE  = 21'h10000;

    // Value of a hex digit; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Byte produced by a simple escape.
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CHR_B:   r = 8'h08;
            CHR_F:   r = 8'h0C;
            CHR_V:   r = 8'h0B;
            CHR_N:   r = 8'h0A;
            CHR_R:   r = 8'h0D;
            CHR_T:   r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    // UTF-8 encoding of one code point.
    function automatic t_grp utf8_encode(input logic [20:0] cp);
        t_grp g;
        g = '0;
        if (cp < UTF8_LIM1) begin
            g.bytes[0] = cp[7:0];
            g.cnt      = 3'd1;
        end else if (cp < UTF8_LIM2) begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.cnt      = 3'd2;
        end else if (cp < UTF8_LIM3) begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.cnt      = 3'd3;
        end else begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.cnt      = 3'd4;
        end
        return g;
    endfunction

endpackage

// ===== rtl/json_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// JSON string body unescaper with UTF-16 escape to UTF-8 transcoding.
// ----------------------------------------------------------------------------
// The unit takes one byte of a JSON string body per request and returns the
// decoded bytes, one per output request. Plain bytes pass through, simple
// escapes become their control bytes or the escaped byte itself, and a \u
// escape (with surrogate pairs joined) becomes at most four UTF-8 bytes. An
// unescaped quote or the end flag closes the string with a result that has
// last set and byte_valid clear. Timing: a request is decoded in the cycle
// it is accepted, and its results appear from the next cycle on. A byte that
// yields one result or none keeps the input at one request per cycle while
// the output is not stalled. A \u escape that yields more than one UTF-8 byte
// stalls the input while the result register emits them, one byte per
// cycle unless the output stalls; the next request is accepted in the same
// cycle in which the last result of the previous group is taken.
module json_string_unescaper_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  jsu_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output jsu_pkg::t_out_req o_out_req
);

    // Result group of the request currently on the input.
    jsu_pkg::t_grp grp;
    // High when the input request is taken at this edge.
    logic          accept;

    // Escape and hex state machine; its state moves only on an accepted request.
    jsu_decoder u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_req),
        .o_grp    (grp)
    );

    // Result register; it also decides when the input may be taken.
    jsu_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_grp       (grp),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

// ===== rtl/jsu_decoder.sv =====
// ----------------------------------------------------------------------------
// jsu_decoder
// Escape and hex state machine; turns one input request into a result group.
// ----------------------------------------------------------------------------
module jsu_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  jsu_pkg::t_in_req i_req,
    output jsu_pkg::t_grp   o_grp
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [11:0]    r_accum, n_accum;
    logic [1:0]     r_count, n_count;
    logic [9:0]     r_high, n_high;
    logic           r_bad, n_bad;

    logic [7:0]  c;
    logic [4:0]  hv;
    logic [3:0]  d;
    logic        nbad;
    logic [15:0] unit;
    logic [20:0] cp;
    logic        e_text;
    logic        e_esc;
    logic        emit;

    assign c    = i_req.in_byte;
    assign hv   = jsu_pkg::hex_value(c);
    assign d    = hv[4] ? 4'd0 : hv[3:0];
    assign nbad = r_bad | hv[4];
    assign unit = nbad ? 16'd0 : {r_accum, d};
    assign cp   = (r_mode == jsu_pkg::MODE_HEX2)
                ? jsu_pkg::SUPPL_BASE + {1'b0, r_high, unit[9:0]}
                : {5'd0, unit};

    // Next state.
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_count = r_count;
        n_high  = r_high;
        n_bad   = r_bad;
        e_text  = 1'b0;
        e_esc   = 1'b0;
        emit    = 1'b0;
        o_grp   = '0;
        if (i_req.is_end) begin
            n_mode     = jsu_pkg::MODE_TEXT;
            n_accum    = '0;
            n_count    = '0;
            n_high     = '0;
            n_bad      = 1'b0;
            o_grp.cnt  = 3'd1;
            o_grp.term = 1'b1;
        end else begin
            case (r_mode)
                jsu_pkg::MODE_ESC: begin
                    n_mode = jsu_pkg::MODE_TEXT;
                    e_esc  = 1'b1;
                end
                jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                    n_accum = {r_accum[7:0], d};
                    n_count = r_count + 2'd1;
                    n_bad   = nbad;
                    if (r_count == 2'd3) begin
                        n_accum = '0;
                        n_count = '0;
                        n_bad   = 1'b0;
                        n_mode  = jsu_pkg::MODE_TEXT;
                        if (r_mode == jsu_pkg::MODE_HEX1) begin
                            if (unit == 16'd0 || (unit >= jsu_pkg::LOW_SURR_LO
                                    && unit <= jsu_pkg::LOW_SURR_HI)) begin
                                emit = 1'b0;
                            end else if (unit >= jsu_pkg::HIGH_SURR_LO
                                    && unit <= jsu_pkg::HIGH_SURR_HI) begin
                                n_high = unit[9:0];
                                n_mode = jsu_pkg::MODE_WAITBS;
                            end else begin
                                emit = 1'b1;
                            end
                        end else begin
                            n_high = '0;
                            emit   = (unit >= jsu_pkg::LOW_SURR_LO)
                                   && (unit <= jsu_pkg::LOW_SURR_HI);
                        end
                    end
                end
                jsu_pkg::MODE_WAITBS: begin
                    if (c == jsu_pkg::CHR_BSLASH) begin
                        n_mode = jsu_pkg::MODE_WAITU;
                    end else begin
                        n_mode = jsu_pkg::MODE_TEXT;
                        n_high = '0;
                        e_text = 1'b1;
                    end
                end
                jsu_pkg::MODE_WAITU: begin
                    if (c == jsu_pkg::CHR_U) begin
                        n_mode  = jsu_pkg::MODE_HEX2;
                        n_accum = '0;
                        n_count = '0;
                        n_bad   = 1'b0;
                    end else begin
                        n_mode = jsu_pkg::MODE_TEXT;
                        n_high = '0;
                        e_esc  = 1'b1;
                    end
                end
                default: begin
                    n_mode = jsu_pkg::MODE_TEXT;
                    e_text = 1'b1;
                end
            endcase

            if (e_text) begin
                if (c == jsu_pkg::CHR_QUOTE) begin
                    n_mode      = jsu_pkg::MODE_TEXT;
                    n_accum     = '0;
                    n_count     = '0;
                    n_high      = '0;
                    n_bad       = 1'b0;
                    o_grp.cnt   = 3'd1;
                    o_grp.term  = 1'b1;
                    o_grp.quote = 1'b1;
                end else if (c == jsu_pkg::CHR_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else begin
                    o_grp.bytes[0] = c;
                    o_grp.cnt      = 3'd1;
                end
            end

            if (e_esc) begin
                if (c == jsu_pkg::CHR_U) begin
                    n_mode  = jsu_pkg::MODE_HEX1;
                    n_accum = '0;
                    n_count = '0;
                    n_bad   = 1'b0;
                end else begin
                    o_grp.bytes[0] = jsu_pkg::esc_map(c);
                    o_grp.cnt      = 3'd1;
                end
            end

            if (emit) begin
                o_grp = jsu_pkg::utf8_encode(cp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= jsu_pkg::MODE_TEXT;
            r_accum <= '0;
            r_count <= '0;
            r_high  <= '0;
            r_bad   <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_count <= n_count;
            r_high  <= n_high;
            r_bad   <= n_bad;
        end
    end

endmodule

// ===== rtl/jsu_serializer.sv =====
// ----------------------------------------------------------------------------
// jsu_serializer
// Result register holding one result group; one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  jsu_pkg::t_grp    i_grp,
    output logic             o_in_stall,
    output logic             o_accept,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output jsu_pkg::t_out_req o_out_req
);

    jsu_pkg::t_grp r_grp;
    logic          r_valid, n_valid;
    logic [1:0]    r_idx, n_idx;
    logic [2:0]    cnt_m1;
    logic          out_take;
    logic          grp_done;

    assign cnt_m1     = r_grp.cnt - 3'd1;
    assign out_take   = r_valid && !i_out_stall;
    assign grp_done   = out_take && ({1'b0, r_idx} == cnt_m1);
    assign o_in_stall = r_valid && !grp_done;
    assign o_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid               = r_valid;
    assign o_out_req.out_byte        = r_grp.term ? 8'd0 : r_grp.bytes[r_idx];
    assign o_out_req.byte_valid      = !r_grp.term;
    assign o_out_req.last            = r_grp.term;
    assign o_out_req.closed_by_quote = r_grp.term && r_grp.quote;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_accept && i_grp.cnt != 3'd0) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (grp_done) begin
            n_valid = 1'b0;
            n_idx   = 2'd0;
        end else if (out_take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept && i_grp.cnt != 3'd0) begin
            r_grp <= i_grp;
        end
    end

endmodule

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level assertions for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input jsu_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input jsu_pkg::t_out_req o_out_req
);

    // A stalled output request stays offered.
    `JSU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled output request keeps its payload.
    `JSU_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_req))

    // The input only waits on a result that is still pending.
    `JSU_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // An accepted end flag shows up next cycle as the closing result.
    `JSU_ASSERT_NXT(a_end_close, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_req.is_end, o_out_valid && o_out_req.last && !o_out_req.byte_valid && !o_out_req.closed_by_quote)

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

// ===== tb/json_string_unescaper_checker.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper_checker
// Watches both channels of the unescaper, decodes every accepted request
// with its own copy of the decoder state and compares the output requests,
// field by field and in order, against the decoded bytes it expects.
// ----------------------------------------------------------------------------
module json_string_unescaper_checker
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_in_req  i_in_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_out_req i_out_req,
    output int       o_err_count,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_F = 8'h66;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // Decoder state, mirrored from what the block should hold.
    t_mode       cur_mode;
    logic [15:0] hex_acc;
    logic [2:0]  digits_seen;
    logic [9:0]  held_high;
    logic        digit_bad;

    // Output requests still owed by the block, oldest first.
    t_out_req    decoded_q[$];

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd16;
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            v = c - DIGIT_0;
        end else if (c >= LOWER_A && c <= LOWER_F) begin
            v = c - LOWER_A + 8'd10;
        end else if (c >= UPPER_A && c <= UPPER_F) begin
            v = c - UPPER_A + 8'd10;
        end
        return v[4:0];
    endfunction

    task automatic clear_decoder();
        cur_mode    = MODE_TEXT;
        hex_acc     = '0;
        digits_seen = '0;
        held_high   = '0;
        digit_bad   = 1'b0;
    endtask

    task automatic start_unit(input t_mode next_mode);
        cur_mode    = next_mode;
        hex_acc     = '0;
        digits_seen = '0;
        digit_bad   = 1'b0;
    endtask

    task automatic expect_byte(input logic [7:0] b);
        t_out_req r;
        r.out_byte        = b;
        r.byte_valid      = 1'b1;
        r.last            = 1'b0;
        r.closed_by_quote = 1'b0;
        decoded_q.push_back(r);
    endtask

    task automatic expect_close(input logic by_quote);
        t_out_req r;
        r.out_byte        = 8'h00;
        r.byte_valid      = 1'b0;
        r.last            = 1'b1;
        r.closed_by_quote = by_quote;
        decoded_q.push_back(r);
    endtask

    task automatic expect_code_point(input logic [20:0] cp);
        if (cp < UTF8_LIM1) begin
            expect_byte(cp[7:0]);
        end else if (cp < UTF8_LIM2) begin
            expect_byte(LEAD2 | 8'(cp >> 6));
            expect_byte(CONT | 8'(cp & 21'h3F));
        end else if (cp < UTF8_LIM3) begin
            expect_byte(LEAD3 | 8'(cp >> 12));
            expect_byte(CONT | 8'((cp >> 6) & 21'h3F));
            expect_byte(CONT | 8'(cp & 21'h3F));
        end else begin
            expect_byte(LEAD4 | 8'((cp >> 18) & 21'h07));
            expect_byte(CONT | 8'((cp >> 12) & 21'h3F));
            expect_byte(CONT | 8'((cp >> 6) & 21'h3F));
            expect_byte(CONT | 8'(cp & 21'h3F));
        end
    endtask

    // Byte that follows a backslash.
    task automatic expect_escaped(input logic [7:0] c);
        case (c)
            CHR_B:   expect_byte(8'h08);
            CHR_F:   expect_byte(8'h0C);
            CHR_V:   expect_byte(8'h0B);
            CHR_N:   expect_byte(8'h0A);
            CHR_R:   expect_byte(8'h0D);
            CHR_T:   expect_byte(8'h09);
            CHR_U:   start_unit(MODE_HEX1);
            default: expect_byte(c);
        endcase
    endtask

    task automatic expect_text(input logic [7:0] c);
        if (c == CHR_QUOTE) begin
            clear_decoder();
            expect_close(1'b1);
        end else if (c == CHR_BSLASH) begin
            cur_mode = MODE_ESC;
        end else begin
            expect_byte(c);
        end
    endtask

    task automatic decode_request(input t_in_req r);
        logic [4:0]  d;
        logic [15:0] unit;
        if (r.is_end) begin
            clear_decoder();
            expect_close(1'b0);
        end else begin
            case (cur_mode)
                MODE_ESC: begin
                    cur_mode = MODE_TEXT;
                    expect_escaped(r.in_byte);
                end
                MODE_HEX1, MODE_HEX2: begin
                    d = digit_value(r.in_byte);
                    if (d[4]) begin
                        digit_bad = 1'b1;
                        d = '0;
                    end
                    hex_acc     = {hex_acc[11:0], d[3:0]};
                    digits_seen = digits_seen + 3'd1;
                    if (digits_seen == 3'd4) begin
                        unit        = digit_bad ? 16'h0000 : hex_acc;
                        hex_acc     = '0;
                        digits_seen = '0;
                        digit_bad   = 1'b0;
                        if (cur_mode == MODE_HEX1) begin
                            cur_mode = MODE_TEXT;
                            if (unit == 16'h0000 ||
                                (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI)) begin
                                // Dropped without output.
                            end else if (unit >= HIGH_SURR_LO && unit <= HIGH_SURR_HI) begin
                                held_high = unit[9:0];
                                cur_mode  = MODE_WAITBS;
                            end else begin
                                expect_code_point({5'd0, unit});
                            end
                        end else begin
                            cur_mode = MODE_TEXT;
                            if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI) begin
                                expect_code_point(SUPPL_BASE + {1'b0, held_high, unit[9:0]});
                            end
                            held_high = '0;
                        end
                    end
                end
                MODE_WAITBS: begin
                    if (r.in_byte == CHR_BSLASH) begin
                        cur_mode = MODE_WAITU;
                    end else begin
                        cur_mode  = MODE_TEXT;
                        held_high = '0;
                        expect_text(r.in_byte);
                    end
                end
                MODE_WAITU: begin
                    if (r.in_byte == CHR_U) begin
                        start_unit(MODE_HEX2);
                    end else begin
                        cur_mode  = MODE_TEXT;
                        held_high = '0;
                        expect_escaped(r.in_byte);
                    end
                end
                default: begin
                    cur_mode = MODE_TEXT;
                    expect_text(r.in_byte);
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_err_count++;
        end
    endtask

    task automatic check_result(input t_out_req got);
        t_out_req want;
        if (decoded_q.size() == 0) begin
            $error("output request with nothing expected: out_byte %h valid %b last %b quote %b",
                   got.out_byte, got.byte_valid, got.last, got.closed_by_quote);
            o_err_count++;
        end else begin
            want = decoded_q.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            check_field("last", 8'(want.last), 8'(got.last));
            check_field("closed_by_quote", 8'(want.closed_by_quote),
                        8'(got.closed_by_quote));
        end
    endtask

    // Results of a request appear in the cycle after it is taken at the earliest,
    // so the order of the two updates below does not matter.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            decoded_q.delete();
            o_err_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                decode_request(i_in_req);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_req);
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== tb/tb_json_string_unescaper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_unit
// Drives JSON string bodies into the unescaper and reports the verdict.
// ----------------------------------------------------------------------------
// A short directed string opens the run: byte extremes, escaped quote and
// backslash, a two-byte and a four-byte \u escape, and both ways of closing a
// string. After that, random fragments of string text are sent: plain bytes,
// simple escapes, single \u units of every size class, surrogate pairs with
// broken variants, spoiled hex digits, quotes and end flags, some of them cut
// short by an end flag. Both sides pause in random bursts, the receiver holds
// off once for a long stretch, and the tail of the run goes at full rate. The
// checker beside the block predicts and compares every output request.
// ----------------------------------------------------------------------------
module tb_json_string_unescaper_unit;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 430;   // requests sent in all, at least
    localparam int QUIET_ITEMS = 60;    // final requests sent with no idling
    localparam int LONG_HOLD   = 200;   // cycles of the long receiver hold-off
    localparam int DRAIN_WAIT  = 20;    // cycles watched after the last result

    localparam logic [7:0] DIGIT_0 = 8'h30;
    localparam logic [7:0] DIGIT_9 = 8'h39;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_F = 8'h46;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_F = 8'h66;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall;
    t_out_req out_req;

    int       fail_count;
    int       pending_results;
    int       items_sent;

    // Set by the stimulus process, read by the receiver process.
    bit       quiet_tail;
    bit       start_long_hold;

    // Bytes of the fragment being built before it is sent.
    logic [7:0] piece_q[$];

    json_string_unescaper_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req)
    );

    json_string_unescaper_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_req   (out_req),
        .o_err_count (fail_count),
        .o_pending   (pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run, several times the slowest correct run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Sends one request. Called at a falling edge and returns at the falling
    // edge after the request was taken. An idle burst may come first; valid
    // is only raised again in a later step than the one that lowered it.
    task automatic send_req(input logic [7:0] b, input logic is_end);
        t_in_req r;
        r.in_byte = b;
        r.is_end  = is_end;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_req(s[i], 1'b0);
        end
    endtask

    // Appends a \u escape for the given unit. A spoiled unit has one digit
    // replaced by a byte that is not a hex digit, quite often a quote or a
    // backslash, which the block must still swallow as a digit.
    task automatic push_unit(input logic [15:0] u, input bit spoil);
        logic [3:0] nib;
        logic [7:0] ch;
        int         bad_pos;
        bad_pos = spoil ? $urandom_range(0, 3) : 4;
        piece_q.push_back(CHR_BSLASH);
        piece_q.push_back(CHR_U);
        for (int i = 3; i >= 0; i--) begin
            nib = u[i*4 +: 4];
            if (nib < 4'd10) begin
                ch = DIGIT_0 + nib;
            end else begin
                ch = ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + nib - 8'd10;
            end
            if (i == bad_pos) begin
                case ($urandom_range(0, 3))
                    0:       ch = CHR_QUOTE;
                    1:       ch = CHR_BSLASH;
                    default: ch = 8'($urandom);
                endcase
                if (ch inside {[DIGIT_0:DIGIT_9], [UPPER_A:UPPER_F], [LOWER_A:LOWER_F]}) begin
                    ch = CHR_QUOTE;
                end
            end
            piece_q.push_back(ch);
        end
    endtask

    // Sends the built fragment. Now and then it is cut short and the string
    // is ended by the end flag partway through it, which may be inside an escape or a unit.
    task automatic flush_piece();
        int cut;
        cut = piece_q.size();
        if (cut > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, piece_q.size() - 1);
        end
        for (int i = 0; i < cut; i++) begin
            send_req(piece_q[i], 1'b0);
        end
        if (cut < piece_q.size()) begin
            send_req(8'($urandom), 1'b1);
        end
        piece_q.delete();
    endtask

    // Builds one random fragment of string text.
    task automatic build_piece();
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] u;
        logic [7:0]  c;
        int          kind;
        int          sel;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            // Raw bytes, any value.
            repeat ($urandom_range(1, 4)) piece_q.push_back(8'($urandom));
        end else if (kind < 40) begin
            piece_q.push_back(CHR_BSLASH);
            case ($urandom_range(0, 9))
                0:       piece_q.push_back(CHR_B);
                1:       piece_q.push_back(CHR_F);
                2:       piece_q.push_back(CHR_V);
                3:       piece_q.push_back(CHR_N);
                4:       piece_q.push_back(CHR_R);
                5:       piece_q.push_back(CHR_T);
                6:       piece_q.push_back(CHR_QUOTE);
                7:       piece_q.push_back(CHR_BSLASH);
                default: piece_q.push_back(8'($urandom));
            endcase
        end else if (kind < 65) begin
            // A single unit from each size class of the UTF-8 output, plus
            // the units that must be dropped.
            case ($urandom_range(0, 5))
                0: u = 16'($urandom_range(16'h0001, 16'h007F));
                1: u = 16'($urandom_range(16'h0080, 16'h07FF));
                2: u = $urandom_range(0, 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                            : 16'($urandom_range(16'hE000, 16'hFFFF));
                3: u = 16'h0000;
                4: u = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
                default: u = 16'($urandom);
            endcase
            push_unit(u, $urandom_range(0, 9) == 0);
        end else if (kind < 85) begin
            hi  = 16'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI));
            lo  = 16'($urandom_range(LOW_SURR_LO, LOW_SURR_HI));
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // Corners of the supplementary range.
                hi = $urandom_range(0, 1) ? HIGH_SURR_LO : HIGH_SURR_HI;
                lo = $urandom_range(0, 1) ? LOW_SURR_LO : LOW_SURR_HI;
            end
            push_unit(hi, 1'b0);
            case (sel)
                6: begin
                    // Second half outside the low surrogate range.
                    push_unit($urandom_range(0, 1) ? 16'($urandom_range(0, 16'hDBFF))
                                                   : 16'($urandom_range(16'hE000, 16'hFFFF)),
                              1'b0);
                end
                7: begin
                    // High surrogate followed by a quote or a random byte.
                    piece_q.push_back($urandom_range(0, 1) ? CHR_QUOTE : 8'($urandom));
                end
                8: begin
                    // High surrogate followed by a different escape.
                    c = 8'($urandom);
                    if (c == CHR_U) begin
                        c = CHR_N;
                    end
                    piece_q.push_back(CHR_BSLASH);
                    piece_q.push_back(c);
                end
                9:       push_unit(lo, 1'b1);
                default: push_unit(lo, 1'b0);
            endcase
        end else if (kind < 95) begin
            piece_q.push_back(CHR_QUOTE);
        end
        // The remaining kinds send a bare end flag with nothing before it.
        if (piece_q.size() == 0) begin
            send_req(8'($urandom), 1'b1);
        end else begin
            flush_piece();
        end
    endtask

    // Receiver: random stall bursts and runs, one long hold-off on request,
    // and no stalls at all once the tail of the run is reached.
    initial begin
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            if (start_long_hold) begin
                start_long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_req          = '0;
        items_sent      = 0;
        quiet_tail      = 1'b0;
        start_long_hold = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed string: plain byte, the zero byte passing as text, the
        // top byte value, escaped quote and backslash, a two-byte and a
        // four-byte code point, then the closing quote and an end flag.
        send_text("A");
        send_req(8'h00, 1'b0);
        send_req(8'hFF, 1'b0);
        send_text("\\\"\\\\\\u00e9\\uD83D\\uDE00\"");
        send_req(8'($urandom), 1'b1);

        // Random part; the receiver holds off for a long stretch while the
        // sender keeps offering requests, so that the block backs up.
        start_long_hold = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            build_piece();
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
                quiet_tail = 1'b1;
            end
        end
        in_valid <= 1'b0;

        // Wait for every expected output request, then watch a little longer
        // for anything the block sends that was never expected.
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decoder.sv
rtl/jsu_serializer.sv
rtl/json_string_unescaper_unit.sv
rtl/jsu_checker.sv
tb/json_string_unescaper_checker.sv
tb/tb_json_string_unescaper_unit.sv
